### rtl/dms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dms_pkg: shared constants, types and sine table
// Widths, controller command and status structs, divider source codes and the
// quarter-wave sine table of the dft magnitude engine.
// ----------------------------------------------------------------------------
package dms_pkg;

  // frame and field widths
  localparam int MAX_SAMPLES = 1024;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int LEN_W       = ADDR_W + 1;
  localparam int CNT_W       = LEN_W;
  localparam int BINS        = 512;
  localparam int K_W         = $clog2(BINS);
  localparam int BIN_W       = 9;
  localparam int SAMPLE_W    = 16;
  localparam int MAG_W       = 15;
  localparam int MAG_MAX     = 32767;

  // phase and sine table
  localparam int PHASE_W     = 12;
  localparam int QTR         = 1024;
  localparam int QIDX_W      = 11;
  localparam int SIN_W       = 15;

  // datapath widths
  localparam int PROD_W      = 33;
  localparam int ACC_W       = 42;
  localparam int A_W         = ACC_W - (SAMPLE_W - 1);
  localparam int SQ_W        = 2 * A_W;
  localparam int RT_W        = 28;
  localparam int RAD_W       = 2 * RT_W;
  localparam int DIV_W       = 28;

  // fixed iteration counts
  localparam int DRAIN_CYC   = 3;

  // divider dividend sources
  localparam logic [1:0] DSRC_BIN  = 2'd0;
  localparam logic [1:0] DSRC_STEP = 2'd1;
  localparam logic [1:0] DSRC_ROOT = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic              load;
    logic              capture;
    logic              div_load;
    logic [1:0]        div_src;
    logic              div_step;
    logic              run_init;
    logic              issue;
    logic              abs_en;
    logic              sq_en;
    logic              root_load;
    logic              root_step;
    logic              out_load;
    logic [ADDR_W-1:0] addr;
  } dms_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [LEN_W-1:0] flen;
    logic             out_busy;
  } dms_stat_t;

  // quarter-wave sine, taylor series in q30 then rounded to q15
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] TAYLOR_DIV [1:7] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

  typedef logic [SIN_W-1:0] qsin_tab_t [0:QTR];

  function automatic logic [SIN_W-1:0] qsine(input int unsigned i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    x    = (64'(i) * PI_Q30) / 64'd2048;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int j = 1; j <= 7; j++) begin
      term = (term * x2) >> 30;
      term = term / TAYLOR_DIV[j];
      if (j % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 64'sd16384) >>> 15;
    if (acc > MAG_MAX) begin
      acc = MAG_MAX;
    end
    return acc[SIN_W-1:0];
  endfunction

  function automatic qsin_tab_t build_qsin();
    qsin_tab_t t;
    for (int i = 0; i <= QTR; i++) begin
      t[i] = qsine(i);
    end
    return t;
  endfunction

  localparam qsin_tab_t QSIN_TAB = build_qsin();

endpackage
`default_nettype wire

### rtl/dms_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dms_if: request and result channels
// Valid/ready channels carrying one request and one result transaction.
// ----------------------------------------------------------------------------
interface dms_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [dms_pkg::SAMPLE_W-1:0]   sample;
  logic                           last;
  logic [dms_pkg::BIN_W-1:0]      bin;

  modport source (output valid, func, sample, last, bin, input ready);
  modport sink   (input valid, func, sample, last, bin, output ready);
endinterface

interface dms_out_if;
  logic                           valid;
  logic                           ready;
  logic [dms_pkg::MAG_W-1:0]      magnitude;
  logic [dms_pkg::BIN_W-1:0]      bin_echo;
  logic                           no_frame;

  modport source (output valid, magnitude, bin_echo, no_frame, input ready);
  modport sink   (input valid, magnitude, bin_echo, no_frame, output ready);
endinterface
`default_nettype wire

### rtl/dms_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dms_ctrl: sequencer of the dft magnitude engine
// Takes requests, steps the shared divider, the sample loop, the square root
// and the output load, issuing one command word per cycle.
// ----------------------------------------------------------------------------
module dms_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_func,
  output logic                     in_ready,
  input  wire dms_pkg::dms_stat_t  stat,
  output dms_pkg::dms_cmd_t        cmd
);
  import dms_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MODK  = 4'd1;
  localparam logic [3:0] S_PLOAD = 4'd2;
  localparam logic [3:0] S_PDIV  = 4'd3;
  localparam logic [3:0] S_INIT  = 4'd4;
  localparam logic [3:0] S_RUN   = 4'd5;
  localparam logic [3:0] S_DRAIN = 4'd6;
  localparam logic [3:0] S_ABS   = 4'd7;
  localparam logic [3:0] S_SQ    = 4'd8;
  localparam logic [3:0] S_SUM   = 4'd9;
  localparam logic [3:0] S_ROOT  = 4'd10;
  localparam logic [3:0] S_RLOAD = 4'd11;
  localparam logic [3:0] S_NDIV  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  logic             div_done;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign div_done = (cnt_r == CNT_W'(DIV_W - 1));

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 1'b1;
    cmd       = '0;
    cmd.addr  = cnt_r[ADDR_W-1:0];
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          if (!in_func) begin
            cmd.load = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            if (stat.flen == '0) begin
              state_nxt = S_OUT;
            end else begin
              cmd.div_load = 1'b1;
              cmd.div_src  = DSRC_BIN;
              state_nxt    = S_MODK;
            end
          end
        end
      end
      S_MODK: begin
        cmd.div_step = 1'b1;
        if (div_done) begin
          state_nxt = S_PLOAD;
        end
      end
      S_PLOAD: begin
        cmd.div_load = 1'b1;
        cmd.div_src  = DSRC_STEP;
        cnt_nxt      = '0;
        state_nxt    = S_PDIV;
      end
      S_PDIV: begin
        cmd.div_step = 1'b1;
        if (div_done) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.run_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_RUN;
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        if (cnt_r == stat.flen - 1'b1) begin
          cnt_nxt   = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (cnt_r == CNT_W'(DRAIN_CYC - 1)) begin
          state_nxt = S_ABS;
        end
      end
      S_ABS: begin
        cmd.abs_en = 1'b1;
        state_nxt  = S_SQ;
      end
      S_SQ: begin
        cmd.sq_en = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.root_load = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt_r == CNT_W'(RT_W - 1)) begin
          state_nxt = S_RLOAD;
        end
      end
      S_RLOAD: begin
        cmd.div_load = 1'b1;
        cmd.div_src  = DSRC_ROOT;
        cnt_nxt      = '0;
        state_nxt    = S_NDIV;
      end
      S_NDIV: begin
        cmd.div_step = 1'b1;
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/dms_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dms_datapath: frame store, mac pipeline, divider, square root, output
// Executes controller commands; one shared restoring divider serves bin
// reduction, phase step and the final scaling.
// ----------------------------------------------------------------------------
module dms_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [dms_pkg::SAMPLE_W-1:0]  in_sample,
  input  wire logic                          in_last,
  input  wire logic [dms_pkg::BIN_W-1:0]     in_bin,
  input  wire dms_pkg::dms_cmd_t             cmd,
  output dms_pkg::dms_stat_t                 stat,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [dms_pkg::MAG_W-1:0]          out_magnitude,
  output logic [dms_pkg::BIN_W-1:0]          out_bin_echo,
  output logic                               out_no_frame
);
  import dms_pkg::*;

  // frame store and fill state
  logic [SAMPLE_W-1:0] mem [0:MAX_SAMPLES-1];
  logic [LEN_W-1:0]    fill_r, flen_r, fill_inc;
  logic                room;

  // request capture
  logic [BIN_W-1:0]    bin_r;
  logic                nf_r;

  // divider
  logic [DIV_W-1:0]    dvd_r;
  logic [LEN_W-1:0]    rem_r;
  logic [LEN_W:0]      div_t;
  logic                div_ge;

  // phase walk
  logic [PHASE_W-1:0]  ph_r, qs_r, ph_nxt, cph;
  logic [LEN_W-1:0]    pr_r, rs_r, pr_nxt;
  logic [LEN_W:0]      pr_sum;
  logic                pr_ge;
  logic [QIDX_W-1:0]   sidx, cidx;

  // mac pipeline
  logic [SAMPLE_W-1:0]      mq_r;
  logic [SIN_W-1:0]         smag_r, cmag_r;
  logic                     sneg_r, cneg_r, v1_r, v2_r;
  logic signed [SIN_W+1:0]  sv, cv;
  logic signed [PROD_W-1:0] ps_r, pc_r;
  logic signed [ACC_W-1:0]  re_r, im_r;

  // magnitude
  logic [ACC_W-1:0]    re_abs, im_abs;
  logic [A_W-1:0]      a_r, b_r;
  logic [SQ_W-1:0]     sqa_r, sqb_r;
  logic [RAD_W-1:0]    rv_r, res_r, bit_r, rt_t;

  // output register
  logic                ov_r;
  logic [MAG_W-1:0]    mag_r;
  logic [BIN_W-1:0]    echo_r;
  logic                onf_r;

  assign room     = (fill_r < LEN_W'(MAX_SAMPLES));
  assign fill_inc = room ? fill_r + 1'b1 : fill_r;

  // frame loading
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      flen_r <= '0;
    end else if (cmd.load) begin
      if (in_last) begin
        flen_r <= fill_inc;
        fill_r <= '0;
      end else begin
        fill_r <= fill_inc;
      end
    end
  end

  // store write and sample read
  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      mem[fill_r[ADDR_W-1:0]] <= in_sample;
    end
    mq_r <= mem[cmd.addr];
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      bin_r <= in_bin;
      nf_r  <= (flen_r == '0);
    end
  end

  // restoring divider step
  assign div_t  = {rem_r, dvd_r[DIV_W-1]};
  assign div_ge = (div_t >= {1'b0, flen_r});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r <= '0;
      case (cmd.div_src)
        DSRC_BIN:  dvd_r <= DIV_W'(in_bin[K_W-1:0]);
        DSRC_STEP: dvd_r <= DIV_W'({rem_r, PHASE_W'(0)});
        DSRC_ROOT: dvd_r <= res_r[DIV_W-1:0];
        default:   dvd_r <= '0;
      endcase
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? LEN_W'(div_t - {1'b0, flen_r}) : div_t[LEN_W-1:0];
      dvd_r <= {dvd_r[DIV_W-2:0], div_ge};
    end
  end

  // phase walk: quotient and remainder of idx*k*4096/N advanced per sample
  assign pr_sum = {1'b0, pr_r} + {1'b0, rs_r};
  assign pr_ge  = (pr_sum >= {1'b0, flen_r});
  assign pr_nxt = pr_ge ? LEN_W'(pr_sum - {1'b0, flen_r}) : pr_sum[LEN_W-1:0];
  assign ph_nxt = ph_r + qs_r + PHASE_W'(pr_ge);
  assign cph    = ph_r + PHASE_W'(QTR);

  // quarter-wave folding
  assign sidx = ph_r[PHASE_W-2] ? QIDX_W'(QTR) - QIDX_W'(ph_r[PHASE_W-3:0])
                                : QIDX_W'(ph_r[PHASE_W-3:0]);
  assign cidx = cph[PHASE_W-2] ? QIDX_W'(QTR) - QIDX_W'(cph[PHASE_W-3:0])
                               : QIDX_W'(cph[PHASE_W-3:0]);

  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      ph_r <= '0;
      pr_r <= '0;
      qs_r <= dvd_r[PHASE_W-1:0];
      rs_r <= rem_r;
    end else if (cmd.issue) begin
      ph_r <= ph_nxt;
      pr_r <= pr_nxt;
    end
    smag_r <= QSIN_TAB[sidx];
    cmag_r <= QSIN_TAB[cidx];
    sneg_r <= ph_r[PHASE_W-1];
    cneg_r <= cph[PHASE_W-1];
  end

  // signed table values
  assign sv = sneg_r ? -$signed({2'b00, smag_r}) : $signed({2'b00, smag_r});
  assign cv = cneg_r ? -$signed({2'b00, cmag_r}) : $signed({2'b00, cmag_r});

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (v1_r) begin
      pc_r <= $signed(mq_r) * cv;
      ps_r <= $signed(mq_r) * sv;
    end
  end

  // accumulation
  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      re_r <= '0;
      im_r <= '0;
    end else if (v2_r) begin
      re_r <= re_r + {{(ACC_W-PROD_W){pc_r[PROD_W-1]}}, pc_r};
      im_r <= im_r - {{(ACC_W-PROD_W){ps_r[PROD_W-1]}}, ps_r};
    end
  end

  // magnitude of both parts, rescaled
  assign re_abs = re_r[ACC_W-1] ? ACC_W'(~re_r + 1'b1) : ACC_W'(re_r);
  assign im_abs = im_r[ACC_W-1] ? ACC_W'(~im_r + 1'b1) : ACC_W'(im_r);

  always_ff @(posedge clk) begin
    if (cmd.abs_en) begin
      a_r <= re_abs[ACC_W-1:SAMPLE_W-1];
      b_r <= im_abs[ACC_W-1:SAMPLE_W-1];
    end
    if (cmd.sq_en) begin
      sqa_r <= a_r * a_r;
      sqb_r <= b_r * b_r;
    end
  end

  // bitwise integer square root, one result bit per step
  assign rt_t = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (cmd.root_load) begin
      rv_r  <= RAD_W'(sqa_r) + RAD_W'(sqb_r);
      res_r <= '0;
      bit_r <= RAD_W'(1) << (RAD_W - 2);
    end else if (cmd.root_step) begin
      if (rv_r >= rt_t) begin
        rv_r  <= rv_r - rt_t;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.out_load) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      echo_r <= bin_r;
      onf_r  <= nf_r;
      if (nf_r) begin
        mag_r <= '0;
      end else if (dvd_r > DIV_W'(MAG_MAX)) begin
        mag_r <= MAG_W'(MAG_MAX);
      end else begin
        mag_r <= dvd_r[MAG_W-1:0];
      end
    end
  end

  assign out_valid     = ov_r;
  assign out_magnitude = mag_r;
  assign out_bin_echo  = echo_r;
  assign out_no_frame  = onf_r;

  assign stat.flen     = flen_r;
  assign stat.out_busy = ov_r && !out_ready;

endmodule
`default_nettype wire

### rtl/dft_magnitude_spectrum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dft_magnitude_spectrum: direct dft bin magnitude engine
// Loads a frame of q1.15 samples and returns sqrt(re^2+im^2)/N for one bin.
// ----------------------------------------------------------------------------
// channel  dir  handshake        payload
// in_ch    in   valid / ready    func, sample, last, bin
// out_ch   out  valid / ready    magnitude, bin_echo, no_frame
//
// a sample load leaves the sequencer idle and ready for the next request; a bin
// request over a frame of N samples holds off further requests until its result
// is loaded for output; its run is the one-sample-per-cycle multiply-accumulate
// loop over the frame store read port plus three 28-step passes of the shared
// divider and one 28-step pass of the square root
// reset is synchronous, active low; the frame store holds no reset value
// a result waits in the output register while loads continue to be taken;
// a later bin result stalls in its final cycle until that register drains
// ----------------------------------------------------------------------------
module dft_magnitude_spectrum (
  input wire logic  clk,
  input wire logic  rst_n,
  dms_in_if.sink    in_ch,
  dms_out_if.source out_ch
);
  import dms_pkg::*;

  dms_cmd_t  cmd;
  dms_stat_t stat;

  // sequencer
  dms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  dms_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_sample     (in_ch.sample),
    .in_last       (in_ch.last),
    .in_bin        (in_ch.bin),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_magnitude (out_ch.magnitude),
    .out_bin_echo  (out_ch.bin_echo),
    .out_no_frame  (out_ch.no_frame)
  );

  // at most one datapath operation per cycle, request capture apart
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.div_load, cmd.div_step, cmd.run_init, cmd.issue,
              cmd.abs_en, cmd.sq_en, cmd.root_load, cmd.root_step, cmd.out_load}))
    else $error("overlapping datapath commands");

  // frame length never exceeds the store
  a_flen_cap: assert property (@(posedge clk) disable iff (!rst_n)
    stat.flen <= LEN_W'(MAX_SAMPLES))
    else $error("frame length beyond store depth");

  // a result appears only after the controller loads it
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.out_load))
    else $error("result valid without output load");

endmodule
`default_nettype wire
